[src/kmsd_pkg.sv]
// Shared types and constants for the keypad matrix scanner with debounce.
// No dependencies; imported by kmsd_keys, keypad_matrix_scan_debounce and the testbench.
package kmsd_pkg;

  // Keypad geometry
  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  // Only the four rows carried in the request are ever sampled
  localparam int ROWS_USED = (ROWS < 4) ? ROWS : 4;
  localparam int COL_W     = (COLS > 1) ? $clog2(COLS) : 1;

  // Field and register widths
  localparam int TIME_W    = 32;
  localparam int STEP_W    = 8;
  localparam int DEB_W     = 10;
  localparam int LEVELS_W  = 4;
  localparam int POS_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'd1;

  // Request kinds carried in tuser
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  // Column scan request from the timing logic to the key store
  typedef struct packed {
    logic                en;
    logic [COL_W-1:0]    col;
    logic [TIME_W-1:0]   now;
    logic [LEVELS_W-1:0] levels;
    logic [DEB_W-1:0]    settle_time;
  } scan_req_t;

endpackage

[src/keypad_matrix_scan_debounce.sv]
// Top level of the keypad matrix scanner with per-key debounce.
// Depends on kmsd_pkg and kmsd_keys.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready   | tuser: cmd; tdata: row_levels
//  m_*     | out | m_tvalid / m_tready   | tdata: drive_col, key_valid, key_row,
//          |     |                       |        key_col, key_pending
//  cfg_*   | in  | cfg_we                | cfg_index, cfg_wdata
//
// One request per cycle; its result appears in the output register on the
// next cycle. All state is updated in the accepting cycle through one pass of
// five parallel 32-bit timestamp subtracts. A new request is taken while the
// output register is empty or being drained in the same cycle. Synchronous
// reset clears all key state, time counters and the pending key at once.
module keypad_matrix_scan_debounce (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [3:0] row_levels
  input  logic                               s_tuser,   // [0] cmd
  // Result channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // [1:0] drive_col,
                                                        // [2] key_valid,
                                                        // [4:3] key_row,
                                                        // [6:5] key_col,
                                                        // [7] key_pending
  // Configuration
  input  logic                               cfg_we,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmsd_pkg::CFG_W-1:0]         cfg_wdata
);
  import kmsd_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  logic [STEP_W-1:0]    scan_interval;
  logic [DEB_W-1:0]     settle_time;
  logic [TIME_W-1:0]    ms_time;
  logic [TIME_W-1:0]    next_scan_time;
  logic [COL_W-1:0]     active_column;
  logic                 pending_flag;
  logic [POS_W-1:0]     pending_row;
  logic [POS_W-1:0]     pending_col;

  logic                 in_acc;
  logic                 is_tick;
  logic [TIME_W-1:0]    scan_diff;
  logic                 scan_due;
  logic [COL_W-1:0]     col_next;
  scan_req_t            scan_req;
  logic [ROWS_USED-1:0] press_ev;
  logic                 hit;
  logic [POS_W-1:0]     hit_row;
  logic                 pending_next;
  logic [POS_W-1:0]     pend_row_next;
  logic [POS_W-1:0]     pend_col_next;
  logic                 key_valid;
  logic [POS_W-1:0]     key_row;
  logic [POS_W-1:0]     key_col;

  // Take a request while the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign is_tick  = s_tuser == CMD_TICK;

  // Scan time check and column advance
  assign scan_diff = ms_time - next_scan_time;
  assign scan_due  = !scan_diff[TIME_W-1];
  assign col_next  = (active_column >= COL_LAST) ? '0 : active_column + COL_W'(1);

  always_comb begin
    scan_req.en          = in_acc && is_tick && scan_due;
    scan_req.col         = active_column;
    scan_req.now         = ms_time;
    scan_req.levels      = s_tdata[LEVELS_W-1:0];
    scan_req.settle_time = settle_time;
  end

  kmsd_keys u_keys (
    .clk      (clk),
    .rst      (rst),
    .req      (scan_req),
    .press_ev (press_ev)
  );

  // Pick the lowest row with a new stable press
  always_comb begin
    hit_row = '0;
    for (int r = ROWS_USED - 1; r >= 0; r--) begin
      if (press_ev[r]) begin
        hit_row = POS_W'(r);
      end
    end
  end

  assign hit = (press_ev != '0) && !pending_flag;

  // Result fields and the pending key after this request
  always_comb begin
    pend_row_next = hit ? hit_row : pending_row;
    pend_col_next = hit ? POS_W'(active_column) : pending_col;
    key_valid     = 1'b0;
    key_row       = '0;
    key_col       = '0;
    if (is_tick) begin
      pending_next = pending_flag || hit;
      if (pending_next) begin
        key_row = pend_row_next;
        key_col = pend_col_next;
      end
    end else begin
      pending_next = 1'b0;
      if (pending_flag) begin
        key_valid = 1'b1;
        key_row   = pending_row;
        key_col   = pending_col;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_interval <= STEP_W'(1);
      settle_time   <= DEB_W'(20);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_STEP: scan_interval <= cfg_wdata[STEP_W-1:0];
        CFG_DEBOUNCE:  settle_time   <= cfg_wdata[DEB_W-1:0];
        default:       ;
      endcase
    end
  end

  // Time base, scan schedule and pending key
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_time        <= '0;
      next_scan_time <= '0;
      active_column  <= '0;
      pending_flag   <= 1'b0;
      pending_row    <= '0;
      pending_col    <= '0;
    end else if (in_acc) begin
      pending_flag <= pending_next;
      pending_row  <= pend_row_next;
      pending_col  <= pend_col_next;
      if (is_tick) begin
        ms_time <= ms_time + TIME_W'(1);
        if (scan_due) begin
          next_scan_time <= ms_time + TIME_W'(scan_interval);
          active_column  <= col_next;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_tdata <= {pending_next, key_col, key_row, key_valid,
                  POS_W'(scan_req.en ? col_next : active_column)};
    end
  end

  // A returned key is never still pending
  a_valid_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[7]))
    else $error("returned key still marked pending");

  // Key position is zero when nothing is returned or pending
  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2] && !m_tdata[7]) |-> (m_tdata[6:3] == '0))
    else $error("key position reported without a key");

  // The pending key is dropped only by a consume request
  a_drop_consume: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(pending_flag)) |-> $past(in_acc && !is_tick))
    else $error("pending key lost without consume");

endmodule

[src/kmsd_keys.sv]
// Per-key raw level, stable level and change timestamp for the whole matrix.
// Depends on kmsd_pkg; updates the keys of one column per scan request.
module kmsd_keys (
  input  logic                                clk,
  input  logic                                rst,
  input  kmsd_pkg::scan_req_t                 req,
  output logic [kmsd_pkg::ROWS_USED-1:0]      press_ev
);
  import kmsd_pkg::*;

  logic [COLS-1:0]   raw_lvl    [ROWS_USED];
  logic [COLS-1:0]   stable_lvl [ROWS_USED];
  logic [TIME_W-1:0] chg_time   [ROWS_USED][COLS];

  for (genvar r = 0; r < ROWS_USED; r++) begin : g_row
    logic              pressed;
    logic              rd_raw;
    logic              rd_stable;
    logic [TIME_W-1:0] held;
    logic              changed;
    logic              settled;

    // Look at the key of this row in the scanned column
    always_comb begin
      pressed   = !req.levels[r];
      rd_raw    = raw_lvl[r][req.col];
      rd_stable = stable_lvl[r][req.col];
      held      = req.now - chg_time[r][req.col];
      changed   = pressed != rd_raw;
      settled   = !held[TIME_W-1] && (held >= TIME_W'(req.settle_time)) &&
                  (rd_stable != pressed);
    end

    assign press_ev[r] = req.en && !changed && settled && pressed;

    // Restart the timer on a raw change, else promote a settled level
    always_ff @(posedge clk) begin
      if (rst) begin
        raw_lvl[r]    <= '0;
        stable_lvl[r] <= '0;
        for (int c = 0; c < COLS; c++) begin
          chg_time[r][c] <= '0;
        end
      end else if (req.en) begin
        if (changed) begin
          raw_lvl[r][req.col]  <= pressed;
          chg_time[r][req.col] <= req.now;
        end else if (settled) begin
          stable_lvl[r][req.col] <= pressed;
        end
      end
    end
  end

  // Stable levels of row 0 move only on a scan
  a_stable_hold: assert property (@(posedge clk) disable iff (rst)
    !req.en |=> $stable(stable_lvl[0]))
    else $error("stable level changed without a scan");

  // A press event needs a scan
  a_press_scan: assert property (@(posedge clk) disable iff (rst)
    (press_ev != '0) |-> req.en)
    else $error("press event outside a scan");

  // After a scan the row 0 raw level follows the sampled row
  a_raw_follow: assert property (@(posedge clk) disable iff (rst)
    req.en |=> raw_lvl[0][$past(req.col)] == !$past(req.levels[0]))
    else $error("raw level does not follow sample");

endmodule

[dv/testbench.sv]
// Self-checking testbench for keypad_matrix_scan_debounce.
// Needs kmsd_pkg and the keypad_matrix_scan_debounce RTL; mirrors the scan and
// debounce rules in a scoreboard class and checks every result field.
`timescale 1ns / 1ps

module testbench;
  import kmsd_pkg::*;

  // Result fields as packed on m_tdata, lowest bits last
  typedef struct packed {
    logic       key_pending;
    logic [1:0] key_col;
    logic [1:0] key_row;
    logic       key_valid;
    logic [1:0] drive_col;
  } key_result_t;

  // Keypad model: predicts each result and checks it on arrival
  class keypad_scoreboard;
    logic [STEP_W-1:0]      step_ms;
    logic [DEB_W-1:0]       settle_ms;
    logic [TIME_W-1:0]      ms_now;
    logic [TIME_W-1:0]      next_scan;
    logic [1:0]             active_col;
    logic [ROWS*COLS-1:0]   raw_pressed;
    logic [ROWS*COLS-1:0]   stable_pressed;
    logic [TIME_W-1:0]      changed_at [ROWS*COLS];
    logic                   key_latched;
    logic [1:0]             latched_row;
    logic [1:0]             latched_col;
    key_result_t            expected_q [$];
    int                     errors;
    int                     requests_seen;
    int                     results_seen;

    function new();
      step_ms        = 8'd1;
      settle_ms      = 10'd20;
      ms_now         = '0;
      next_scan      = '0;
      active_col     = '0;
      raw_pressed    = '0;
      stable_pressed = '0;
      foreach (changed_at[i]) changed_at[i] = '0;
      key_latched    = 1'b0;
      latched_row    = '0;
      latched_col    = '0;
      errors         = 0;
      requests_seen  = 0;
      results_seen   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_SCAN_STEP) begin
        step_ms = value[STEP_W-1:0];
      end else begin
        settle_ms = value[DEB_W-1:0];
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Advance the model by one request and queue the result it must produce
    function void note_request(logic cmd, logic [LEVELS_W-1:0] levels);
      key_result_t want;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] held;
      logic pressed;
      int idx;
      want = '0;
      requests_seen++;
      if (cmd == CMD_TICK) begin
        now  = ms_now;
        held = now - next_scan;
        // Scan the active column once its time has come
        if (!held[TIME_W-1]) begin
          next_scan = now + step_ms;
          for (int r = 0; r < ROWS_USED; r++) begin
            idx     = r * COLS + int'(active_col);
            pressed = ~levels[r];
            if (pressed != raw_pressed[idx]) begin
              raw_pressed[idx] = pressed;
              changed_at[idx]  = now;
            end else begin
              held = now - changed_at[idx];
              if (!held[TIME_W-1] && held >= settle_ms && stable_pressed[idx] != pressed) begin
                stable_pressed[idx] = pressed;
                if (!key_latched && pressed) begin
                  key_latched = 1'b1;
                  latched_row = r[1:0];
                  latched_col = active_col;
                end
              end
            end
          end
          active_col = (int'(active_col) == COLS - 1) ? 2'd0 : active_col + 2'd1;
        end
        ms_now = now + 1;
        if (key_latched) begin
          want.key_row = latched_row;
          want.key_col = latched_col;
        end
      end else if (key_latched) begin
        // Hand out the latched key and clear it
        want.key_valid = 1'b1;
        want.key_row   = latched_row;
        want.key_col   = latched_col;
        key_latched    = 1'b0;
      end
      want.drive_col   = active_col;
      want.key_pending = key_latched;
      expected_q.push_back(want);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Compare one result against the oldest prediction, field by field
    function void check_result(logic [7:0] data);
      key_result_t got;
      key_result_t want;
      got.drive_col   = data[1:0];
      got.key_valid   = data[2];
      got.key_row     = data[4:3];
      got.key_col     = data[6:5];
      got.key_pending = data[7];
      results_seen++;
      if (expected_q.size() == 0) begin
        note_error($sformatf("mismatch: result %0d (%h) with no request outstanding",
                             results_seen, data));
        return;
      end
      want = expected_q.pop_front();
      if (got.drive_col !== want.drive_col || got.key_valid !== want.key_valid ||
          got.key_row !== want.key_row || got.key_col !== want.key_col ||
          got.key_pending !== want.key_pending) begin
        note_error($sformatf({"mismatch: result %0d drive_col %0d/%0d key_valid %0d/%0d ",
                              "key_row %0d/%0d key_col %0d/%0d key_pending %0d/%0d ",
                              "(expected/actual)"},
                             results_seen, want.drive_col, got.drive_col,
                             want.key_valid, got.key_valid, want.key_row, got.key_row,
                             want.key_col, got.key_col, want.key_pending, got.key_pending));
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  keypad_scoreboard sb = new();

  // Keys held on the simulated keypad, bit r*COLS+c for row r, column c
  logic [ROWS*COLS-1:0] keys_down = '0;
  int                   hold_left = 0;
  int                   burst_left = 0;

  keypad_matrix_scan_debounce u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[LEVELS_W-1:0]);
    end
  end

  // Offer one request in bursts with random gaps, hold until accepted
  task automatic send_request(input logic cmd, input logic [LEVELS_W-1:0] levels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(8 - LEVELS_W){1'b0}}, levels};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stop offering and let every expected result drain, plus the output stage
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Hold one register write for a single rising edge; the caller drops cfg_we
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic program_timing(input int step, input int settle);
    wait_drained();
    write_register(CFG_SCAN_STEP, CFG_W'(step));
    write_register(CFG_DEBOUNCE, CFG_W'(settle));
    cfg_we <= 1'b0;
  endtask

  // Row levels the keypad presents for one driven column, active low
  function automatic logic [LEVELS_W-1:0] column_levels(logic [1:0] col);
    logic [LEVELS_W-1:0] lv;
    lv = '1;
    for (int r = 0; r < ROWS_USED; r++) lv[r] = ~keys_down[r * COLS + int'(col)];
    return lv;
  endfunction

  // Mostly clean key presses held long enough to settle, some bounce and noise
  task automatic random_request();
    int pick;
    logic [LEVELS_W-1:0] lv;
    if (hold_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) keys_down = '0;
      else if (pick < 8) keys_down = (ROWS*COLS)'(1) << $urandom_range(0, ROWS*COLS - 1);
      else keys_down = (ROWS*COLS)'($urandom);
      hold_left = $urandom_range(5, 60);
    end
    hold_left--;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_request(CMD_CONSUME, LEVELS_W'($urandom));
    end else begin
      lv = column_levels(sb.active_col);
      if (pick < 25) lv[$urandom_range(0, LEVELS_W - 1)] ^= 1'b1;
      if (pick < 28) lv = LEVELS_W'($urandom);
      send_request(CMD_TICK, lv);
    end
  endtask

  // Result side: rotate stall patterns, with one long hold-off mid-run
  initial begin : receiver
    int mode;
    int mode_left;
    bit long_stall_done;
    mode = 0;
    mode_left = 0;
    long_stall_done = 0;
    forever begin
      @(negedge clk);
      if (!long_stall_done && sb.requests_seen >= 230) begin
        long_stall_done = 1;
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((mode_left % 8) < 5);
      endcase
    end
  end

  initial begin : stimulus
    int step_list [6];
    int settle_list [6];
    step_list   = '{1, 0, 2, 0, 3, 1};
    settle_list = '{20, 0, 5, 3, 1, 9};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Nothing latched yet: a consume returns no key
    send_request(CMD_CONSUME, 4'hF);
    send_request(CMD_CONSUME, 4'h0);
    send_request(CMD_TICK, 4'hF);
    send_request(CMD_TICK, 4'h0);

    // Zero step and zero debounce: every tick scans, the second sight settles
    program_timing(0, 0);
    repeat (8) send_request(CMD_TICK, 4'b1110);
    send_request(CMD_TICK, 4'b0111);
    send_request(CMD_CONSUME, 4'h5);
    send_request(CMD_CONSUME, 4'hA);
    repeat (2) send_request(CMD_TICK, 4'hF);

    // Widest settings: the long step leaves later ticks unscanned
    program_timing(255, 1023);
    send_request(CMD_TICK, 4'h0);
    send_request(CMD_TICK, 4'h0);
    send_request(CMD_CONSUME, 4'h0);

    // Random phases, one timing setting each
    for (int phase = 0; phase < 7; phase++) begin
      if (phase < 6) program_timing(step_list[phase], settle_list[phase]);
      else program_timing($urandom_range(0, 4), $urandom_range(0, 30));
      keys_down = '0;
      hold_left = 0;
      for (int n = 0; n < 70; n++) begin
        // Pause the request side once until everything has come back
        if (phase == 1 && n == 35) wait_drained();
        random_request();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS keypad_matrix_scan_debounce");
    end else begin
      $display("FAIL keypad_matrix_scan_debounce");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL keypad_matrix_scan_debounce");
    $finish;
  end

endmodule
